[rtl/stb_pkg.sv]
// Shared types and codes for the soft timer table bank.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package stb_pkg;

   localparam logic [2:0] MODE_TICK    = 3'd0;
   localparam logic [2:0] MODE_START   = 3'd1;
   localparam logic [2:0] MODE_STOP    = 3'd2;
   localparam logic [2:0] MODE_SESSION = 3'd3;
   localparam logic [2:0] MODE_CLEAR   = 3'd4;
   localparam logic [2:0] MODE_WRITE   = 3'd5;

   // Operation applied to each slot during a level walk
   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_START = 2'd1,
      OP_STOP  = 2'd2
   } op_type;

   typedef struct packed {
      logic load_walk;    // capture op, level and id from the request
      logic load_sess;    // capture session mask, clear outer index
      logic wr_direct;    // apply clear ready / write slot from the request
      logic rd_outer;     // read slot at the outer session index
      logic latch_outer;  // take id and start/stop choice from the outer read
      logic rd_inner;     // read slot at the walk index
      logic exec;         // update the slot fetched by rd_inner
      logic next_outer;   // advance the outer session index
      logic push_fin;     // send the final result of the item
   } cmd_type;

   typedef struct packed {
      logic fire_now;
      logic pend_v;
      logic out_free;
      logic j_end;
      logic o_end;
   } stat_type;

endpackage

`default_nettype wire

[rtl/soft_timer_table_bank.sv]
// Soft timer table bank, top level: LEVELS levels of SLOTS timer slots each.
// Depends on stb_pkg, stb_ctrl and stb_dp.
//
// One item is taken at a time. Every slot sits in a single-port memory, so a
// slot is first read and then updated. A tick, start or stop walks every slot
// of its level before its final result, and the walk holds while the result
// side stalls when a tick expires more than one slot. A session switch walks
// each slot's level once per slot. Clear ready, write slot, unused modes and
// walks on a level of LEVELS or more go straight to the final result. Every
// item ends in a result with last set; a tick gives one per expired slot.
`default_nettype none

module soft_timer_table_bank #(
   parameter int SLOTS      = 16,
   parameter int LEVELS     = 4,
   parameter int COUNT_BITS = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [2:0]  req_mode,
   input  wire  [1:0]  req_level,
   input  wire  [15:0] req_event_id,
   input  wire  [7:0]  req_session,
   input  wire  [3:0]  req_slot,
   input  wire         req_slot_cyclic,
   input  wire  [7:0]  req_slot_mask,
   input  wire  [15:0] req_slot_reload,
   input  wire         req_slot_on,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic        rsp_fired,
   output logic [1:0]  rsp_fired_level,
   output logic [3:0]  rsp_fired_slot,
   output logic [15:0] rsp_fired_event,
   output logic        rsp_last
);
   import stb_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   stb_ctrl #(
      .LEVELS(LEVELS)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_mode (req_mode),
      .req_level(req_level),
      .stat     (stat),
      .cmd      (cmd)
   );

   stb_dp #(
      .SLOTS     (SLOTS),
      .LEVELS    (LEVELS),
      .COUNT_BITS(COUNT_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_mode       (req_mode),
      .req_level      (req_level),
      .req_event_id   (req_event_id),
      .req_session    (req_session),
      .req_slot       (req_slot),
      .req_slot_cyclic(req_slot_cyclic),
      .req_slot_mask  (req_slot_mask),
      .req_slot_reload(req_slot_reload),
      .req_slot_on    (req_slot_on),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_fired      (rsp_fired),
      .rsp_fired_level(rsp_fired_level),
      .rsp_fired_slot (rsp_fired_slot),
      .rsp_fired_event(rsp_fired_event),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire

[rtl/stb_ctrl.sv]
// Sequencer of the soft timer table bank: walks levels and slots, paces results.
// Depends on stb_pkg; drives stb_dp through cmd_type, watches stat_type.
`default_nettype none

module stb_ctrl #(
   parameter int LEVELS = 4
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  wire  [2:0]        req_mode,
   input  wire  [1:0]        req_level,
   input  stb_pkg::stat_type stat,
   output stb_pkg::cmd_type  cmd
);
   import stb_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_ORD  = 6'b000010,
      ST_OLAT = 6'b000100,
      ST_RD   = 6'b001000,
      ST_EX   = 6'b010000,
      ST_FIN  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      sess_mode_ff, sess_mode_in;
   logic      acc, lvl_ok, walk, sess;

   assign req_stall = (state_ff != ST_IDLE);
   assign acc       = req_valid && (state_ff == ST_IDLE);
   assign lvl_ok    = (32'(req_level) < LEVELS);
   assign walk      = lvl_ok && (req_mode == MODE_TICK || req_mode == MODE_START ||
                                 req_mode == MODE_STOP);
   assign sess      = (req_mode == MODE_SESSION);

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      sess_mode_in = sess_mode_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               cmd.load_walk = walk;
               cmd.load_sess = sess;
               cmd.wr_direct = !walk && !sess;
               sess_mode_in  = sess;
               if (walk) state_in = ST_RD;
               else if (sess) state_in = ST_ORD;
               else state_in = ST_FIN;
            end
         end
         ST_ORD: begin
            cmd.rd_outer = 1'b1;
            state_in     = ST_OLAT;
         end
         ST_OLAT: begin
            cmd.latch_outer = 1'b1;
            state_in        = ST_RD;
         end
         ST_RD: begin
            cmd.rd_inner = 1'b1;
            state_in     = ST_EX;
         end
         ST_EX: begin
            // hold while a second expiry has no room to move the first one out
            if (!(stat.fire_now && stat.pend_v && !stat.out_free)) begin
               cmd.exec = 1'b1;
               priority if (!stat.j_end) begin
                  state_in = ST_RD;
               end else if (sess_mode_ff && !stat.o_end) begin
                  cmd.next_outer = 1'b1;
                  state_in       = ST_ORD;
               end else begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_FIN: begin
            if (stat.out_free) begin
               cmd.push_fin = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sess_mode_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sess_mode_ff <= sess_mode_in;
      end
   end

endmodule

`default_nettype wire

[rtl/stb_dp.sv]
// Datapath of the soft timer table bank: slot memories, on/ready flags,
// walk indexes, pending expiry and result register. Depends on stb_pkg.
`default_nettype none

module stb_dp #(
   parameter int SLOTS      = 16,
   parameter int LEVELS     = 4,
   parameter int COUNT_BITS = 16
) (
   input  wire               clock,
   input  wire               reset,
   input  stb_pkg::cmd_type  cmd,
   output stb_pkg::stat_type stat,
   input  wire  [2:0]        req_mode,
   input  wire  [1:0]        req_level,
   input  wire  [15:0]       req_event_id,
   input  wire  [7:0]        req_session,
   input  wire  [3:0]        req_slot,
   input  wire               req_slot_cyclic,
   input  wire  [7:0]        req_slot_mask,
   input  wire  [15:0]       req_slot_reload,
   input  wire               req_slot_on,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output logic              rsp_fired,
   output logic [1:0]        rsp_fired_level,
   output logic [3:0]        rsp_fired_slot,
   output logic [15:0]       rsp_fired_event,
   output logic              rsp_last
);
   import stb_pkg::*;

   localparam int N  = LEVELS * SLOTS;
   localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int AW = (N > 1) ? $clog2(N) : 1;

   function automatic logic [AW-1:0] slot_addr(input logic [LW-1:0] l,
                                                input logic [SW-1:0] s);
      slot_addr = AW'(32'(l) * SLOTS + 32'(s));
   endfunction

   // slot memories
   logic [15:0]           ev_mem  [N];
   logic                  cyc_mem [N];
   logic [7:0]            ses_mem [N];
   logic [COUNT_BITS-1:0] rld_mem [N];
   logic [COUNT_BITS-1:0] cnt_mem [N];

   logic [15:0]           rd_ev_ff;
   logic                  rd_cyc_ff;
   logic [7:0]            rd_ses_ff;
   logic [COUNT_BITS-1:0] rd_rld_ff, rd_cnt_ff;
   logic                  rd_sv_ff, rd_cv_ff;

   logic [N-1:0] en_ff, en_in, rdy_ff, rdy_in, swr_ff, swr_in, cwr_ff, cwr_in;

   op_type          op_ff, op_in;
   logic [LW-1:0]   lvl_ff, lvl_in, ol_ff, ol_in;
   logic [SW-1:0]   j_ff, j_in, os_ff, os_in;
   logic [15:0]     id_ff, id_in;
   logic [7:0]      sess_ff, sess_in;

   logic            pv_ff, pv_in;
   logic [LW-1:0]   pl_ff, pl_in;
   logic [SW-1:0]   ps_ff, ps_in;
   logic [15:0]     pe_ff, pe_in;

   logic            rv_ff, rv_in, rf_ff, rf_in, rlast_ff, rlast_in;
   logic [1:0]      rl_ff, rl_in;
   logic [3:0]      rs_ff, rs_in;
   logic [15:0]     re_ff, re_in;

   logic [AW-1:0]   ia, oa, ra, da, cnt_wa;
   logic            st_re, st_we, cnt_we, direct_ok, act, match, fire_now, push;
   logic [15:0]     ev_q;
   logic            cyc_q;
   logic [7:0]      ses_q;
   logic [COUNT_BITS-1:0] rld_q, cnt_q, dec, cnt_wd, req_rld;

   assign ia      = slot_addr(lvl_ff, j_ff);
   assign oa      = slot_addr(ol_ff, os_ff);
   assign ra      = cmd.rd_outer ? oa : ia;
   assign st_re   = cmd.rd_outer || cmd.rd_inner;
   assign da      = slot_addr(LW'(req_level), SW'(req_slot));
   assign req_rld = COUNT_BITS'(req_slot_reload);
   assign direct_ok = cmd.wr_direct && (32'(req_level) < LEVELS) && (32'(req_slot) < SLOTS);

   // entries never written read as their reset value of zero
   assign ev_q  = rd_sv_ff ? rd_ev_ff  : '0;
   assign cyc_q = rd_sv_ff ? rd_cyc_ff : 1'b0;
   assign ses_q = rd_sv_ff ? rd_ses_ff : '0;
   assign rld_q = rd_sv_ff ? rd_rld_ff : '0;
   assign cnt_q = rd_cv_ff ? rd_cnt_ff : '0;

   assign act      = en_ff[ia] && !rdy_ff[ia];
   assign dec      = (cnt_q != '0) ? cnt_q - 1'b1 : '0;
   assign match    = (ev_q == id_ff);
   assign fire_now = (op_ff == OP_TICK) && act && (dec == '0);
   assign push     = (cmd.exec && fire_now && pv_ff) || cmd.push_fin;

   always_comb begin
      en_in  = en_ff;
      rdy_in = rdy_ff;
      swr_in = swr_ff;
      cwr_in = cwr_ff;
      st_we  = 1'b0;
      cnt_we = 1'b0;
      cnt_wa = ia;
      cnt_wd = '0;
      if (cmd.exec) begin
         unique case (op_ff)
            OP_TICK: begin
               if (act) begin
                  cnt_we = 1'b1;
                  if (dec == '0) begin
                     rdy_in[ia] = 1'b1;
                     en_in[ia]  = cyc_q;
                     cnt_wd     = cyc_q ? rld_q : '0;
                  end else begin
                     cnt_wd = dec;
                  end
               end
            end
            OP_START: begin
               if (match && !en_ff[ia]) begin
                  en_in[ia] = 1'b1;
                  cnt_we    = 1'b1;
                  cnt_wd    = rld_q;
               end
            end
            OP_STOP: begin
               if (match && en_ff[ia]) begin
                  en_in[ia] = 1'b0;
                  cnt_we    = 1'b1;
               end
            end
            default: ;
         endcase
      end
      if (direct_ok && req_mode == MODE_CLEAR) begin
         rdy_in[da] = 1'b0;
      end
      if (direct_ok && req_mode == MODE_WRITE) begin
         st_we      = 1'b1;
         swr_in[da] = 1'b1;
         en_in[da]  = req_slot_on;
         cnt_we     = 1'b1;
         cnt_wa     = da;
         cnt_wd     = req_slot_on ? req_rld : '0;
      end
      if (cnt_we) cwr_in[cnt_wa] = 1'b1;
   end

   always_comb begin
      op_in   = op_ff;
      lvl_in  = lvl_ff;
      id_in   = id_ff;
      j_in    = j_ff;
      ol_in   = ol_ff;
      os_in   = os_ff;
      sess_in = sess_ff;
      if (cmd.load_walk) begin
         priority if (req_mode == MODE_START) op_in = OP_START;
         else if (req_mode == MODE_STOP) op_in = OP_STOP;
         else op_in = OP_TICK;
         lvl_in = LW'(req_level);
         id_in  = req_event_id;
         j_in   = '0;
      end
      if (cmd.load_sess) begin
         sess_in = req_session;
         ol_in   = '0;
         os_in   = '0;
      end
      if (cmd.latch_outer) begin
         op_in  = ((ses_q & sess_ff) == '0) ? OP_STOP : OP_START;
         lvl_in = ol_ff;
         id_in  = ev_q;
         j_in   = '0;
      end
      if (cmd.exec) j_in = j_ff + 1'b1;
      if (cmd.next_outer) begin
         if (os_ff == SW'(SLOTS - 1)) begin
            os_in = '0;
            ol_in = ol_ff + 1'b1;
         end else begin
            os_in = os_ff + 1'b1;
         end
      end
   end

   // hold the newest expiry back so the last one can carry the last flag
   always_comb begin
      pv_in    = pv_ff;
      pl_in    = pl_ff;
      ps_in    = ps_ff;
      pe_in    = pe_ff;
      rv_in    = rv_ff && rsp_stall;
      rf_in    = rf_ff;
      rl_in    = rl_ff;
      rs_in    = rs_ff;
      re_in    = re_ff;
      rlast_in = rlast_ff;
      if (push) begin
         rv_in    = 1'b1;
         rf_in    = pv_ff;
         rl_in    = pv_ff ? 2'(pl_ff) : '0;
         rs_in    = pv_ff ? 4'(ps_ff) : '0;
         re_in    = pv_ff ? pe_ff : '0;
         rlast_in = cmd.push_fin;
      end
      if (cmd.exec && fire_now) begin
         pv_in = 1'b1;
         pl_in = lvl_ff;
         ps_in = j_ff;
         pe_in = ev_q;
      end
      if (cmd.push_fin) pv_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         ev_mem[da]  <= req_event_id;
         cyc_mem[da] <= req_slot_cyclic;
         ses_mem[da] <= req_slot_mask;
         rld_mem[da] <= req_rld;
      end
      if (st_re) begin
         rd_ev_ff  <= ev_mem[ra];
         rd_cyc_ff <= cyc_mem[ra];
         rd_ses_ff <= ses_mem[ra];
         rd_rld_ff <= rld_mem[ra];
         rd_sv_ff  <= swr_ff[ra];
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
      if (cmd.rd_inner) begin
         rd_cnt_ff <= cnt_mem[ia];
         rd_cv_ff  <= cwr_ff[ia];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff  <= '0;
         rdy_ff <= '0;
         swr_ff <= '0;
         cwr_ff <= '0;
         pv_ff  <= 1'b0;
         rv_ff  <= 1'b0;
         op_ff  <= OP_TICK;
         j_ff   <= '0;
         ol_ff  <= '0;
         os_ff  <= '0;
      end else begin
         en_ff  <= en_in;
         rdy_ff <= rdy_in;
         swr_ff <= swr_in;
         cwr_ff <= cwr_in;
         pv_ff  <= pv_in;
         rv_ff  <= rv_in;
         op_ff  <= op_in;
         j_ff   <= j_in;
         ol_ff  <= ol_in;
         os_ff  <= os_in;
      end
   end

   always_ff @(posedge clock) begin
      lvl_ff   <= lvl_in;
      id_ff    <= id_in;
      sess_ff  <= sess_in;
      pl_ff    <= pl_in;
      ps_ff    <= ps_in;
      pe_ff    <= pe_in;
      rf_ff    <= rf_in;
      rl_ff    <= rl_in;
      rs_ff    <= rs_in;
      re_ff    <= re_in;
      rlast_ff <= rlast_in;
   end

   assign stat.fire_now = fire_now;
   assign stat.pend_v   = pv_ff;
   assign stat.out_free = !rv_ff || !rsp_stall;
   assign stat.j_end    = (j_ff == SW'(SLOTS - 1));
   assign stat.o_end    = (ol_ff == LW'(LEVELS - 1)) && (os_ff == SW'(SLOTS - 1));

   assign rsp_valid       = rv_ff;
   assign rsp_fired       = rf_ff;
   assign rsp_fired_level = rl_ff;
   assign rsp_fired_slot  = rs_ff;
   assign rsp_fired_event = re_ff;
   assign rsp_last        = rlast_ff;

endmodule

`default_nettype wire

[rtl/stb_checker.sv]
// Port-level checks for the soft timer table bank, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module stb_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_valid,
   input wire        req_stall,
   input wire        rsp_valid,
   input wire        rsp_stall,
   input wire        rsp_fired,
   input wire [1:0]  rsp_fired_level,
   input wire [3:0]  rsp_fired_slot,
   input wire [15:0] rsp_fired_event,
   input wire        rsp_last
);

   // one item at a time: a transfer in closes the request side
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while an item is in progress");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_fired) &&
         $stable(rsp_last) && $stable(rsp_fired_event) && $stable(rsp_fired_slot)))
      else $error("stalled result changed");

   a_ack_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_fired) |-> (rsp_last && rsp_fired_event == 16'd0 &&
         rsp_fired_slot == 4'd0 && rsp_fired_level == 2'd0))
      else $error("acknowledge result malformed");

   // a non-final result can only be pending while the item still holds the request side
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> req_stall)
      else $error("non-final result while idle");

endmodule

bind soft_timer_table_bank stb_checker u_stb_checker (.*);

`default_nettype wire

[bench/soft_timer_table_bank_checker.sv]
// Checker for the soft timer table bank: watches both channels, keeps its own
// copy of the timer table, predicts the results of each transfer and compares.
// Depends on stb_pkg for the mode codes.
`default_nettype none

module soft_timer_table_bank_checker (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   input  wire         req_stall,
   input  wire  [2:0]  req_mode,
   input  wire  [1:0]  req_level,
   input  wire  [15:0] req_event_id,
   input  wire  [7:0]  req_session,
   input  wire  [3:0]  req_slot,
   input  wire         req_slot_cyclic,
   input  wire  [7:0]  req_slot_mask,
   input  wire  [15:0] req_slot_reload,
   input  wire         req_slot_on,
   input  wire         rsp_valid,
   input  wire         rsp_stall,
   input  wire         rsp_fired,
   input  wire  [1:0]  rsp_fired_level,
   input  wire  [3:0]  rsp_fired_slot,
   input  wire  [15:0] rsp_fired_event,
   input  wire         rsp_last,
   output int          fail_count,
   output int          pending
);
   import stb_pkg::*;

   localparam int NSLOT = 16;
   localparam int NLVL  = 4;

   typedef struct packed {
      logic        fired;
      logic [1:0]  lvl;
      logic [3:0]  slot;
      logic [15:0] ev;
      logic        last;
   } expiry_t;

   logic [15:0] tm_event  [NLVL*NSLOT];
   logic        tm_on     [NLVL*NSLOT];
   logic        tm_cyclic [NLVL*NSLOT];
   logic [7:0]  tm_mask   [NLVL*NSLOT];
   logic [15:0] tm_reload [NLVL*NSLOT];
   logic [15:0] tm_count  [NLVL*NSLOT];
   logic        tm_ready  [NLVL*NSLOT];

   expiry_t expected_q[$];

   assign pending = expected_q.size();

   task automatic start_id(input int lv, input logic [15:0] id);
      for (int i = 0; i < NSLOT; i++) begin
         if (tm_event[lv*NSLOT+i] == id && !tm_on[lv*NSLOT+i]) begin
            tm_on[lv*NSLOT+i] = 1'b1;
            tm_count[lv*NSLOT+i] = tm_reload[lv*NSLOT+i];
         end
      end
   endtask

   task automatic stop_id(input int lv, input logic [15:0] id);
      for (int i = 0; i < NSLOT; i++) begin
         if (tm_event[lv*NSLOT+i] == id && tm_on[lv*NSLOT+i]) begin
            tm_on[lv*NSLOT+i] = 1'b0;
            tm_count[lv*NSLOT+i] = '0;
         end
      end
   endtask

   task automatic apply_transfer();
      int e;
      int n;
      expiry_t r;
      n = 0;
      case (req_mode)
         MODE_TICK: begin
            for (int i = 0; i < NSLOT; i++) begin
               e = int'(req_level)*NSLOT + i;
               if (tm_on[e] && !tm_ready[e]) begin
                  if (tm_count[e] != 0) tm_count[e]--;
                  if (tm_count[e] == 0) begin
                     tm_ready[e] = 1'b1;
                     r = '{1'b1, req_level, i[3:0], tm_event[e], 1'b0};
                     expected_q.push_back(r);
                     n++;
                     if (tm_cyclic[e]) tm_count[e] = tm_reload[e];
                     else tm_on[e] = 1'b0;
                  end
               end
            end
         end
         MODE_START: start_id(int'(req_level), req_event_id);
         MODE_STOP:  stop_id(int'(req_level), req_event_id);
         MODE_SESSION: begin
            for (int l = 0; l < NLVL; l++) begin
               for (int i = 0; i < NSLOT; i++) begin
                  if ((tm_mask[l*NSLOT+i] & req_session) == 8'd0)
                     stop_id(l, tm_event[l*NSLOT+i]);
                  else
                     start_id(l, tm_event[l*NSLOT+i]);
               end
            end
         end
         MODE_CLEAR: tm_ready[int'(req_level)*NSLOT+int'(req_slot)] = 1'b0;
         MODE_WRITE: begin
            e = int'(req_level)*NSLOT + int'(req_slot);
            tm_event[e]  = req_event_id;
            tm_cyclic[e] = req_slot_cyclic;
            tm_mask[e]   = req_slot_mask;
            tm_reload[e] = req_slot_reload;
            tm_on[e]     = req_slot_on;
            tm_count[e]  = req_slot_on ? req_slot_reload : 16'd0;
         end
         default: ;
      endcase
      if (n == 0) begin
         r = '{1'b0, 2'd0, 4'd0, 16'd0, 1'b1};
         expected_q.push_back(r);
      end else begin
         expected_q[expected_q.size()-1].last = 1'b1;
      end
   endtask

   task automatic compare_result();
      expiry_t x;
      if (expected_q.size() == 0) begin
         $error("result transfer with nothing expected");
         fail_count++;
         return;
      end
      x = expected_q.pop_front();
      if (rsp_fired !== x.fired) begin
         $error("fired: expected %0d, got %0d", x.fired, rsp_fired); fail_count++;
      end
      if (rsp_fired_level !== x.lvl) begin
         $error("fired_level: expected %0d, got %0d", x.lvl, rsp_fired_level);
         fail_count++;
      end
      if (rsp_fired_slot !== x.slot) begin
         $error("fired_slot: expected %0d, got %0d", x.slot, rsp_fired_slot);
         fail_count++;
      end
      if (rsp_fired_event !== x.ev) begin
         $error("fired_event: expected %0h, got %0h", x.ev, rsp_fired_event);
         fail_count++;
      end
      if (rsp_last !== x.last) begin
         $error("last: expected %0d, got %0d", x.last, rsp_last); fail_count++;
      end
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      if (reset) begin
         expected_q.delete();
         for (int e = 0; e < NLVL*NSLOT; e++) begin
            tm_event[e] = '0; tm_on[e] = 1'b0; tm_cyclic[e] = 1'b0;
            tm_mask[e] = '0; tm_reload[e] = '0; tm_count[e] = '0;
            tm_ready[e] = 1'b0;
         end
      end else begin
         // results of an earlier transfer leave before a new one is predicted
         if (rsp_valid && !rsp_stall) compare_result();
         if (req_valid && !req_stall) apply_transfer();
      end
   end

endmodule

`default_nettype wire

[bench/soft_timer_table_bank_test.sv]
// Testbench top for the soft timer table bank: drives directed and random
// timer commands with random idling on both sides. Depends on stb_pkg, the
// block and soft_timer_table_bank_checker.
`default_nettype none

module soft_timer_table_bank_test;
   import stb_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_mode = '0;
   logic [1:0]  req_level = '0;
   logic [15:0] req_event_id = '0;
   logic [7:0]  req_session = '0;
   logic [3:0]  req_slot = '0;
   logic        req_slot_cyclic = 1'b0;
   logic [7:0]  req_slot_mask = '0;
   logic [15:0] req_slot_reload = '0;
   logic        req_slot_on = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_fired;
   logic [1:0]  rsp_fired_level;
   logic [3:0]  rsp_fired_slot;
   logic [15:0] rsp_fired_event;
   logic        rsp_last;
   int          fail_count;
   int          pending;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          cycles = 0;

   always #5 clock = ~clock;

   soft_timer_table_bank dut (.*);
   soft_timer_table_bank_checker checker_i (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("** soft_timer_table_bank: FAILED **");
         $finish;
      end
   end

   always @(negedge clock) rsp_stall <= ($urandom_range(99) < recv_idle_pct);

   // valid stays high into the next call; it drops only while idling
   task automatic send(input logic [2:0] mode, input logic [1:0] lvl,
                       input logic [15:0] id, input logic [7:0] sess,
                       input logic [3:0] sl, input logic cyc,
                       input logic [7:0] mask, input logic [15:0] reload,
                       input logic on);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode; req_level <= lvl; req_event_id <= id;
      req_session <= sess; req_slot <= sl; req_slot_cyclic <= cyc;
      req_slot_mask <= mask; req_slot_reload <= reload; req_slot_on <= on;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // mostly small ids and reloads so that starts, stops and expiries meet
   task automatic random_item();
      logic [15:0] id;
      logic [15:0] rl;
      int pick;
      id = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(3));
      rl = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(4));
      pick = $urandom_range(99);
      if (pick < 35)
         send(MODE_TICK, 2'($urandom), id, 8'($urandom), 4'($urandom), 1'b0, 8'd0,
              16'd0, 1'b0);
      else if (pick < 55)
         send(MODE_WRITE, 2'($urandom), id, 8'($urandom), 4'($urandom),
              1'($urandom), 8'($urandom), rl, 1'($urandom));
      else if (pick < 65)
         send(MODE_START, 2'($urandom), id, 8'd0, 4'($urandom), 1'b0, 8'd0, 16'd0, 1'b0);
      else if (pick < 73)
         send(MODE_STOP, 2'($urandom), id, 8'd0, 4'($urandom), 1'b0, 8'd0, 16'd0, 1'b0);
      else if (pick < 88)
         send(MODE_CLEAR, 2'($urandom), id, 8'd0, 4'($urandom), 1'b0, 8'd0, 16'd0, 1'b0);
      else if (pick < 93)
         send(MODE_SESSION, 2'($urandom), id, 8'($urandom), 4'd0, 1'b0, 8'd0, 16'd0,
              1'b0);
      else
         send(3'($urandom_range(7, 6)), 2'($urandom), 16'($urandom), 8'($urandom),
              4'($urandom), 1'($urandom), 8'($urandom), 16'($urandom), 1'($urandom));
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // directed: extremes, every mode, multiple expiries, cyclic reload
      send(MODE_TICK, 2'd0, 16'd0, 8'd0, 4'd0, 1'b0, 8'd0, 16'd0, 1'b0);
      send(MODE_WRITE, 2'd3, 16'hFFFF, 8'd0, 4'd15, 1'b1, 8'hFF, 16'hFFFF, 1'b0);
      send(MODE_WRITE, 2'd0, 16'h0005, 8'd0, 4'd0, 1'b1, 8'h01, 16'd1, 1'b1);
      send(MODE_WRITE, 2'd0, 16'h0007, 8'd0, 4'd7, 1'b0, 8'h80, 16'd0, 1'b1);
      send(MODE_WRITE, 2'd0, 16'h0005, 8'd0, 4'd15, 1'b0, 8'h02, 16'd2, 1'b0);
      send(MODE_TICK, 2'd0, 16'd0, 8'd0, 4'd0, 1'b0, 8'd0, 16'd0, 1'b0);
      send(MODE_TICK, 2'd0, 16'd0, 8'd0, 4'd0, 1'b0, 8'd0, 16'd0, 1'b0);
      send(MODE_CLEAR, 2'd0, 16'd0, 8'd0, 4'd0, 1'b0, 8'd0, 16'd0, 1'b0);
      send(MODE_START, 2'd0, 16'h0005, 8'd0, 4'd0, 1'b0, 8'd0, 16'd0, 1'b0);
      send(MODE_TICK, 2'd0, 16'd0, 8'd0, 4'd0, 1'b0, 8'd0, 16'd0, 1'b0);
      send(MODE_TICK, 2'd0, 16'd0, 8'd0, 4'd0, 1'b0, 8'd0, 16'd0, 1'b0);
      send(MODE_STOP, 2'd0, 16'h0005, 8'd0, 4'd0, 1'b0, 8'd0, 16'd0, 1'b0);
      send(MODE_START, 2'd3, 16'hFFFF, 8'd0, 4'd0, 1'b0, 8'd0, 16'd0, 1'b0);
      send(MODE_CLEAR, 2'd3, 16'd0, 8'd0, 4'd15, 1'b0, 8'd0, 16'd0, 1'b0);
      send(MODE_SESSION, 2'd0, 16'd0, 8'h01, 4'd0, 1'b0, 8'd0, 16'd0, 1'b0);
      send(MODE_TICK, 2'd0, 16'd0, 8'd0, 4'd0, 1'b0, 8'd0, 16'd0, 1'b0);
      send(MODE_SESSION, 2'd2, 16'd0, 8'h00, 4'd0, 1'b0, 8'd0, 16'd0, 1'b0);
      send(MODE_SESSION, 2'd0, 16'd0, 8'hFF, 4'd0, 1'b0, 8'd0, 16'd0, 1'b0);
      send(3'd6, 2'd1, 16'hA5A5, 8'h5A, 4'd9, 1'b1, 8'h33, 16'h1234, 1'b1);
      send(3'd7, 2'd2, 16'h5A5A, 8'hA5, 4'd6, 1'b0, 8'hCC, 16'hEDCB, 1'b0);
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 52 : 0;
         recv_idle_pct = (ph == 0) ? 52 : (ph == 1) ? 33 : 0;
         repeat (33) random_item();
      end
      req_valid <= 1'b0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("** soft_timer_table_bank: PASSED **");
      else
         $display("** soft_timer_table_bank: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire

[files.f]
rtl/stb_pkg.sv
rtl/stb_ctrl.sv
rtl/stb_dp.sv
rtl/soft_timer_table_bank.sv
rtl/stb_checker.sv
bench/soft_timer_table_bank_checker.sv
bench/soft_timer_table_bank_test.sv
